[hw/rtl/tca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants for the teletext capture adapter core.
// ----------------------------------------------------------------------------
package tca_pkg;

  // row store geometry
  localparam int ROWS         = 16;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int COLUMNS      = 64;
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int PACKET_BYTES = 42;
  localparam int STORE_DEPTH  = ROWS * COLUMNS;
  localparam int STORE_AW     = ROW_W + COL_W;

  // status latch bits and masks
  localparam logic [7:0] STATUS_RESET = 8'h0F;
  localparam logic [7:0] STATUS_CLR   = 8'h2F;  // drops INT, DOR and FSYNC
  localparam logic [7:0] STATUS_NODOR = 8'hBF;
  localparam logic [7:0] STATUS_HIGH  = 8'hF0;
  localparam logic [7:0] STATUS_INT   = 8'h80;
  localparam logic [7:0] STATUS_FSYNC = 8'h10;
  localparam logic [7:0] STATUS_DEW   = 8'h20;
  localparam logic [7:0] READ_IDLE    = 8'hFF;

  // row header bytes
  localparam logic [7:0] HDR_NET   = 8'h27;
  localparam logic [7:0] HDR_LOCAL = 8'h67;

  // configuration defaults
  localparam logic [15:0] FSYNC_TICKS_RESET = 16'd640;
  localparam logic [15:0] DEW_TICKS_RESET   = 16'd2176;
  localparam logic [15:0] FIELD_TICKS_RESET = 16'd37184;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_CAPT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_CTRL  = 2'd0,
    REG_ROW   = 2'd1,
    REG_DATA  = 2'd2,
    REG_CLEAR = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    PH_FIELD = 2'd0,
    PH_FSYNC = 2'd1,
    PH_DEW   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_NETSRC = 3'd1,
    CFG_FSYNC  = 3'd2,
    CFG_DEW    = 3'd3,
    CFG_FIELD  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_HDR
  } state_t;

  // phase length to reload value; zero length acts as one tick
  function automatic logic [15:0] phase_load(input logic [15:0] n);
    return (n == 16'd0) ? 16'd0 : n - 16'd1;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/teletext_capture_adapter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teletext_capture_adapter_core
// Bus registers, field timer and a 16 x 64 byte row store for captured rows.
// ----------------------------------------------------------------------------
//  channel   signals                                       direction
//  in        in_valid/in_ready, mode .. capture_byte       in
//  out       out_valid/out_ready, read_data .. field_phase out
//  cfg       cfg_we, cfg_index, cfg_data                   in
//
//  most items are taken in ST_IDLE alone; a store data read also passes
//  through ST_READ (the row store read port is registered) and a live row
//  header capture through ST_HDR (second beat on the single store write port).
//  after reset the store is swept to zero, one byte a cycle, with in_ready
//  low; configuration writes are taken throughout.
//  a result stage and the output register let the next item enter while a
//  result waits on out_ready.
module teletext_capture_adapter_core
  import tca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [1:0]  reg_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic [3:0]  capture_row,
  input  wire logic [5:0]  capture_pos,
  input  wire logic [7:0]  capture_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             irq_line,
  output logic [1:0]       channel_select,
  output logic [1:0]       field_phase,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic        adapter_enabled;
  logic        network_source;
  logic [15:0] fsync_ticks;
  logic [15:0] dew_ticks;
  logic [15:0] field_ticks;

  // adapter state
  phase_t            phase, phase_next;
  logic [7:0]        status_bits, status_next;
  logic              ints_enable, ints_next;
  logic              capture_enable, capt_en_next;
  logic [1:0]        channel, channel_next;
  logic [ROW_W-1:0]  row_pointer, row_ptr_next;
  logic [COL_W-1:0]  col_pointer, col_ptr_next;
  logic              row_live, live_next;
  logic [15:0]       tick_count, tick_next;
  logic              irq_flag, irq_next;

  // sequencer
  state_t              state, state_next;
  logic [STORE_AW-1:0] clr_addr;
  logic [ROW_W-1:0]    hdr_row;
  logic [7:0]          hdr_byte;
  logic                accept;

  // row store
  logic [7:0]          store_mem [STORE_DEPTH];
  logic [7:0]          mem_q;
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0]          mem_wdata;
  logic [STORE_AW-1:0] mem_raddr;

  // item decode
  logic                wr_item;
  logic [STORE_AW-1:0] wr_addr_item;
  logic [7:0]          wr_data_item;
  logic                rd_item;
  logic                hdr_item;
  logic [7:0]          rdata_item;
  logic [7:0]          s_nodor;
  logic                capt_ok;

  // result stage
  logic       res_valid;
  logic [7:0] res_data;
  logic       res_irq;
  logic [1:0] res_chan;
  logic [1:0] res_phase;
  logic       res_move;

  assign accept    = in_valid && in_ready;
  assign res_move  = res_valid && (!out_valid || out_ready);
  assign mem_raddr = {row_pointer, col_pointer};
  assign s_nodor   = status_bits & STATUS_NODOR;
  assign capt_ok   = ({1'b0, capture_row} < (ROW_W + 1)'(ROWS)) &&
                     (capture_pos < COL_W'(PACKET_BYTES));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      adapter_enabled <= 1'b1;
      network_source  <= 1'b0;
      fsync_ticks     <= FSYNC_TICKS_RESET;
      dew_ticks       <= DEW_TICKS_RESET;
      field_ticks     <= FIELD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: adapter_enabled <= cfg_data[0];
        CFG_NETSRC: network_source  <= cfg_data[0];
        CFG_FSYNC:  fsync_ticks     <= cfg_data;
        CFG_DEW:    dew_ticks       <= cfg_data;
        CFG_FIELD:  field_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effect of the presented item
  always_comb begin
    phase_next   = phase;
    status_next  = status_bits;
    ints_next    = ints_enable;
    capt_en_next = capture_enable;
    channel_next = channel;
    row_ptr_next = row_pointer;
    col_ptr_next = col_pointer;
    live_next    = row_live;
    tick_next    = tick_count;
    irq_next     = irq_flag;
    wr_item      = 1'b0;
    wr_addr_item = {row_pointer, col_pointer};
    wr_data_item = write_data;
    rd_item      = 1'b0;
    hdr_item     = 1'b0;
    rdata_item   = 8'h00;
    if (!adapter_enabled) begin
      if (mode_t'(mode) == MODE_READ) rdata_item = READ_IDLE;
    end else begin
      unique case (mode_t'(mode))
        MODE_WRITE: begin
          unique case (reg_addr_t'(reg_addr))
            REG_CTRL: begin
              ints_next    = write_data[3];
              irq_next     = write_data[3] && status_bits[7];
              capt_en_next = write_data[2];
              channel_next = write_data[1:0];
            end
            REG_ROW: begin
              row_ptr_next = write_data[ROW_W-1:0];
              col_ptr_next = '0;
            end
            REG_DATA: begin
              wr_item      = 1'b1;
              col_ptr_next = col_pointer + COL_W'(1);
            end
            REG_CLEAR: begin
              status_next = status_bits & STATUS_CLR;
              irq_next    = 1'b0;
            end
          endcase
        end
        MODE_READ: begin
          unique case (reg_addr_t'(reg_addr))
            REG_CTRL: rdata_item = status_bits |
                                   ((phase == PH_DEW) ? STATUS_DEW : 8'h00);
            REG_ROW:  rdata_item = 8'h00;
            REG_DATA: begin
              rd_item      = 1'b1;
              col_ptr_next = col_pointer + COL_W'(1);
            end
            REG_CLEAR: begin
              status_next = status_bits & STATUS_CLR;
              irq_next    = 1'b0;
            end
          endcase
        end
        MODE_TICK: begin
          if (tick_count != 16'd0) begin
            tick_next = tick_count - 16'd1;
          end else begin
            unique case (phase)
              PH_FSYNC: begin
                // INT is copied down into DOR on entry to the window
                status_next  = s_nodor | ((s_nodor & STATUS_HIGH) >> 1);
                tick_next    = phase_load(dew_ticks);
                phase_next   = PH_DEW;
                row_ptr_next = '0;
                col_ptr_next = '0;
              end
              PH_DEW: begin
                status_next = status_bits | STATUS_INT;
                tick_next   = phase_load(field_ticks);
                phase_next  = PH_FIELD;
                if (ints_enable) irq_next = 1'b1;
              end
              default: begin
                status_next = status_bits | STATUS_FSYNC;
                tick_next   = phase_load(fsync_ticks);
                phase_next  = PH_FSYNC;
              end
            endcase
          end
        end
        MODE_CAPT: begin
          if (capture_enable && capt_ok) begin
            if (capture_pos == '0) begin
              live_next    = (capture_byte != 8'h00);
              wr_addr_item = {capture_row[ROW_W-1:0], COL_W'(0)};
              if (capture_byte != 8'h00) begin
                // header now, packet byte into column one on the next beat
                wr_item      = 1'b1;
                wr_data_item = network_source ? HDR_NET : HDR_LOCAL;
                hdr_item     = 1'b1;
              end else if (!network_source) begin
                wr_item      = 1'b1;
                wr_data_item = 8'h00;
              end
            end else if (row_live) begin
              wr_item      = 1'b1;
              wr_addr_item = {capture_row[ROW_W-1:0], capture_pos + COL_W'(1)};
              wr_data_item = capture_byte;
            end
          end
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == STORE_AW'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (rd_item)       state_next = ST_READ;
          else if (hdr_item) state_next = ST_HDR;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_HDR:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and store write port
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_item;
    mem_wdata = wr_data_item;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
      end
      ST_IDLE: begin
        in_ready = !res_valid || res_move;
        mem_we   = in_valid && in_ready && wr_item;
      end
      ST_READ: ;
      ST_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = {hdr_row, COL_W'(1)};
        mem_wdata = hdr_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + STORE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_row  <= capture_row[ROW_W-1:0];
      hdr_byte <= capture_byte;
    end
  end

  // row store
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    mem_q <= store_mem[mem_raddr];
  end

  // adapter state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIELD;
      status_bits    <= STATUS_RESET;
      ints_enable    <= 1'b0;
      capture_enable <= 1'b0;
      channel        <= 2'd0;
      row_pointer    <= '0;
      col_pointer    <= '0;
      row_live       <= 1'b0;
      tick_count     <= 16'd0;
      irq_flag       <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      status_bits    <= status_next;
      ints_enable    <= ints_next;
      capture_enable <= capt_en_next;
      channel        <= channel_next;
      row_pointer    <= row_ptr_next;
      col_pointer    <= col_ptr_next;
      row_live       <= live_next;
      tick_count     <= tick_next;
      irq_flag       <= irq_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_READ) begin
      res_valid <= 1'b1;
    end else if (accept) begin
      res_valid <= !rd_item;
    end else if (res_move) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      res_data <= mem_q;
    end else if (accept) begin
      res_data  <= rdata_item;
      res_irq   <= irq_next;
      res_chan  <= channel_next;
      res_phase <= phase_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      read_data      <= res_data;
      irq_line       <= res_irq;
      channel_select <= res_chan;
      field_phase    <= res_phase;
    end
  end

`ifndef SYNTHESIS
  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("item taken during store sweep");

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    accept && rd_item |=> state == ST_READ && !res_valid && !in_ready)
    else $error("store read beat not interlocked");

  a_hdr_beat: assert property (@(posedge clk) disable iff (rst)
    accept && hdr_item |=> mem_we && mem_waddr[COL_W-1:0] == COL_W'(1))
    else $error("header capture missed its second store write");
`endif

endmodule
`default_nettype wire
